// File: rtl/core/imubc_pkg.sv
// Shared types, constants and width helpers for the IMU bias calibration block.
package imubc_pkg;

    localparam int AXIS_COUNT   = 6;
    localparam int GYRO_AXES    = 3;
    localparam int ACCEL_Z_AXIS = 5;
    localparam int AXIS_W       = $clog2(AXIS_COUNT);

    localparam int RAW_W   = 16;
    localparam int CAL_W   = 12;
    localparam int AGAIN_W = 10;
    localparam int GGAIN_W = 7;
    localparam int GRAV_W  = 24;
    localparam int OFS_W   = 27;
    localparam int ACC_W   = 28;
    localparam int GYR_W   = 24;

    localparam int MAX_CAL_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVG_FRAMES,
        CFG_ACCEL_GAIN,
        CFG_GYRO_GAIN,
        CFG_GRAVITY
    } cfg_idx_t;

    localparam logic [CAL_W-1:0]   AVG_FRAMES_RST = 12'd2000;
    localparam logic [AGAIN_W-1:0] ACCEL_GAIN_RST = 10'd244;
    localparam logic [GGAIN_W-1:0] GYRO_GAIN_RST  = 7'd35;
    localparam logic [GRAV_W-1:0]  GRAVITY_RST    = 24'd1000000;

    typedef struct packed {
        logic [CAL_W-1:0]   avg_frames;
        logic [AGAIN_W-1:0] accel_gain;
        logic [GGAIN_W-1:0] gyro_gain;
        logic [GRAV_W-1:0]  gravity_ug;
    } cfg_t;

    typedef struct packed {
        logic              capture;
        logic              accum;
        logic              cal_mul;
        logic              div_load;
        logic              div_step;
        logic              cal_store;
        logic              run_mul;
        logic              run_sub;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
        logic [AXIS_W-1:0] sub_axis;
    } dp_cmd_t;

    typedef struct packed {
        logic cal_reached;
        logic out_free;
    } dp_sts_t;

    // Running sum of raw words over up to 2^cal_bits-1 frames
    function automatic int sum_w(input int cal_bits);
        return cal_bits + RAW_W + 1;
    endfunction

    // Sum times signed-extended gain; also the divider's bit count
    function automatic int prod_w(input int cal_bits);
        return cal_bits + RAW_W + 1 + AGAIN_W + 1;
    endfunction

endpackage

// File: rtl/core/imu_bias_calibrate_and_correct_top.sv
// IMU static bias calibration and correction, top level.
// Calibration frames: no result; the next frame waits until the last one is summed. The frame
// that ends calibration then multiplies, divides (serial offset divider) and stores each axis in turn.
// Corrected frames: one shared multiplier steps over the six axes, then the result is loaded
// into the output register. Output register lets the next frame in while held.
// rst_n (async, low) restores register defaults, clears sums/offsets and restarts calibration.
module imu_bias_calibrate_and_correct_top #(
    parameter int MAX_CAL_BITS = imubc_pkg::MAX_CAL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [imubc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imubc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [imubc_pkg::RAW_W-1:0]  gyro_x,
    input  logic signed [imubc_pkg::RAW_W-1:0]  gyro_y,
    input  logic signed [imubc_pkg::RAW_W-1:0]  gyro_z,
    input  logic signed [imubc_pkg::RAW_W-1:0]  accel_x,
    input  logic signed [imubc_pkg::RAW_W-1:0]  accel_y,
    input  logic signed [imubc_pkg::RAW_W-1:0]  accel_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [imubc_pkg::ACC_W-1:0]  accel_x_ug,
    output logic signed [imubc_pkg::ACC_W-1:0]  accel_y_ug,
    output logic signed [imubc_pkg::ACC_W-1:0]  accel_z_ug,
    output logic signed [imubc_pkg::GYR_W-1:0]  gyro_x_mdps,
    output logic signed [imubc_pkg::GYR_W-1:0]  gyro_y_mdps,
    output logic signed [imubc_pkg::GYR_W-1:0]  gyro_z_mdps
);
    import imubc_pkg::*;

    cfg_t                    cfg;
    dp_cmd_t                 cmd;
    dp_sts_t                 sts;
    logic signed [RAW_W-1:0] raw_in  [AXIS_COUNT];
    logic signed [ACC_W-1:0] res_out [AXIS_COUNT];

    assign raw_in = '{gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z};

    imubc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    imubc_ctrl #(
        .MAX_CAL_BITS (MAX_CAL_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    imubc_dp #(
        .MAX_CAL_BITS (MAX_CAL_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .raw_in    (raw_in),
        .res_out   (res_out),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    assign gyro_x_mdps = $signed(res_out[0][GYR_W-1:0]);
    assign gyro_y_mdps = $signed(res_out[1][GYR_W-1:0]);
    assign gyro_z_mdps = $signed(res_out[2][GYR_W-1:0]);
    assign accel_x_ug  = res_out[3];
    assign accel_y_ug  = res_out[4];
    assign accel_z_ug  = res_out[5];

endmodule

// File: rtl/core/imubc_cfg.sv
// Configuration register file for the IMU bias calibration block.
module imubc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [imubc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imubc_pkg::CFG_DATA_W-1:0] cfg_data,
    output imubc_pkg::cfg_t                  cfg
);
    import imubc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avg_frames <= AVG_FRAMES_RST;
            cfg_reg.accel_gain <= ACCEL_GAIN_RST;
            cfg_reg.gyro_gain  <= GYRO_GAIN_RST;
            cfg_reg.gravity_ug <= GRAVITY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_AVG_FRAMES: cfg_reg.avg_frames <= cfg_data[CAL_W-1:0];
                CFG_ACCEL_GAIN: cfg_reg.accel_gain <= cfg_data[AGAIN_W-1:0];
                CFG_GYRO_GAIN:  cfg_reg.gyro_gain  <= cfg_data[GGAIN_W-1:0];
                CFG_GRAVITY:    cfg_reg.gravity_ug <= cfg_data[GRAV_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/imubc_ctrl.sv
// Control state machine: sequences accumulation, offset division and correction.
module imubc_ctrl #(
    parameter int MAX_CAL_BITS = imubc_pkg::MAX_CAL_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output imubc_pkg::dp_cmd_t cmd,
    input  imubc_pkg::dp_sts_t sts
);
    import imubc_pkg::*;

    localparam int DIV_STEPS = prod_w(MAX_CAL_BITS);
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int STEP_W    = $clog2(AXIS_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_CMUL,
        S_DLOAD,
        S_DIV,
        S_CSTORE,
        S_RUN,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [AXIS_W-1:0] axis_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              calibrated_reg;
    logic              accept;

    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && sts.out_free);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd           = '0;
        cmd.capture   = accept;
        cmd.accum     = (state_reg == S_ACCUM);
        cmd.cal_mul   = (state_reg == S_CMUL);
        cmd.div_load  = (state_reg == S_DLOAD);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.cal_store = (state_reg == S_CSTORE);
        cmd.run_mul   = (state_reg == S_RUN) && (step_reg < STEP_W'(AXIS_COUNT));
        cmd.run_sub   = (state_reg == S_RUN) && (step_reg != '0);
        cmd.out_load  = (state_reg == S_DONE) && sts.out_free;
        cmd.sub_axis  = AXIS_W'(step_reg - 1'b1);
        if (state_reg == S_RUN)
        begin
            cmd.axis = (step_reg < STEP_W'(AXIS_COUNT)) ? step_reg[AXIS_W-1:0] : '0;
        end
        else
        begin
            cmd.axis = axis_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            axis_reg       <= '0;
            step_reg       <= '0;
            cnt_reg        <= '0;
            calibrated_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= calibrated_reg ? S_RUN : S_ACCUM;
                        step_reg  <= '0;
                    end
                end
                S_ACCUM:
                begin
                    if (sts.cal_reached)
                    begin
                        state_reg <= S_CMUL;
                        axis_reg  <= '0;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CMUL:
                begin
                    state_reg <= S_DLOAD;
                end
                S_DLOAD:
                begin
                    state_reg <= S_DIV;
                    cnt_reg   <= '0;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_CSTORE;
                    end
                end
                S_CSTORE:
                begin
                    if (axis_reg == AXIS_W'(AXIS_COUNT - 1))
                    begin
                        calibrated_reg <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_CMUL;
                    end
                end
                S_RUN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(AXIS_COUNT))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (sts.out_free)
                    begin
                        if (accept)
                        begin
                            state_reg <= S_RUN;
                            step_reg  <= '0;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/core/imubc_dp.sv
// Datapath: axis sums, shared multiplier, serial divider, offsets and output register.
module imubc_dp #(
    parameter int MAX_CAL_BITS = imubc_pkg::MAX_CAL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  imubc_pkg::cfg_t                     cfg,
    input  imubc_pkg::dp_cmd_t                  cmd,
    output imubc_pkg::dp_sts_t                  sts,
    input  logic signed [imubc_pkg::RAW_W-1:0]  raw_in  [imubc_pkg::AXIS_COUNT],
    output logic signed [imubc_pkg::ACC_W-1:0]  res_out [imubc_pkg::AXIS_COUNT],
    output logic                                out_valid,
    input  logic                                out_ready
);
    import imubc_pkg::*;

    localparam int SUM_W   = sum_w(MAX_CAL_BITS);
    localparam int PROD_W  = prod_w(MAX_CAL_BITS);
    localparam int REM_W   = MAX_CAL_BITS + 1;
    localparam int GAIN_SW = AGAIN_W + 1;
    localparam int RUNP_W  = RAW_W + GAIN_SW;
    localparam int OSUM_W  = PROD_W + 2;
    localparam int DIFF_W  = ACC_W + 1;

    localparam logic signed [OSUM_W-1:0] OFS_HI =
        {{(OSUM_W - OFS_W + 1){1'b0}}, {(OFS_W - 1){1'b1}}};
    localparam logic signed [OSUM_W-1:0] OFS_LO =
        {{(OSUM_W - OFS_W + 1){1'b1}}, {(OFS_W - 1){1'b0}}};
    localparam logic signed [DIFF_W-1:0] ACC_HI =
        {{(DIFF_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [DIFF_W-1:0] ACC_LO =
        {{(DIFF_W - ACC_W + 1){1'b1}}, {(ACC_W - 1){1'b0}}};
    localparam logic signed [DIFF_W-1:0] GYR_HI =
        {{(DIFF_W - GYR_W + 1){1'b0}}, {(GYR_W - 1){1'b1}}};
    localparam logic signed [DIFF_W-1:0] GYR_LO =
        {{(DIFF_W - GYR_W + 1){1'b1}}, {(GYR_W - 1){1'b0}}};

    logic signed [RAW_W-1:0]  raw_reg  [AXIS_COUNT];
    logic signed [SUM_W-1:0]  sum_reg  [AXIS_COUNT];
    logic signed [OFS_W-1:0]  ofs_reg  [AXIS_COUNT];
    logic signed [ACC_W-1:0]  res_reg  [AXIS_COUNT];
    logic signed [ACC_W-1:0]  out_reg  [AXIS_COUNT];
    logic [MAX_CAL_BITS-1:0]  frames_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0]        quo_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [MAX_CAL_BITS-1:0]  div_d_reg;
    logic                     neg_reg;
    logic                     out_valid_reg;

    logic signed [GAIN_SW-1:0] gain_s;
    logic signed [PROD_W-1:0]  cal_prod;
    logic signed [RUNP_W-1:0]  run_prod;
    logic [MAX_CAL_BITS-1:0]   frames_inc;
    logic [MAX_CAL_BITS-1:0]   need_raw;
    logic [MAX_CAL_BITS-1:0]   need;
    logic [MAX_CAL_BITS-1:0]   divisor;
    logic [PROD_W-1:0]         prod_mag;
    logic [PROD_W-1:0]         dividend;
    logic [REM_W-1:0]          trial;
    logic [REM_W-1:0]          rem_sub;
    logic                      ge;
    logic signed [OSUM_W-1:0]  q_s;
    logic signed [OSUM_W-1:0]  grav_s;
    logic signed [OSUM_W-1:0]  ofs_sum;
    logic signed [OSUM_W-1:0]  ofs_sat;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  res_sat;

    always_comb
    begin
        if (cmd.axis < AXIS_W'(GYRO_AXES))
        begin
            gain_s = $signed({1'b0, AGAIN_W'(cfg.gyro_gain)});
        end
        else
        begin
            gain_s = $signed({1'b0, cfg.accel_gain});
        end
    end

    assign cal_prod = sum_reg[cmd.axis] * gain_s;
    assign run_prod = raw_reg[cmd.axis] * gain_s;

    // Calibration end test
    assign frames_inc      = frames_reg + 1'b1;
    assign need_raw        = MAX_CAL_BITS'(cfg.avg_frames);
    assign need            = (need_raw == '0) ? MAX_CAL_BITS'(1) : need_raw;
    assign sts.cal_reached = (frames_inc >= need);
    assign sts.out_free    = !out_valid_reg || out_ready;

    // Round to nearest: |n| + d/2, then restoring division one bit a cycle
    assign divisor  = (frames_reg == '0) ? MAX_CAL_BITS'(1) : frames_reg;
    assign prod_mag = prod_reg[PROD_W-1] ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign dividend = prod_mag + PROD_W'(frames_reg >> 1);
    assign trial    = {rem_reg[REM_W-2:0], quo_reg[PROD_W-1]};
    assign ge       = (trial >= {1'b0, div_d_reg});
    assign rem_sub  = trial - {1'b0, div_d_reg};

    always_comb
    begin
        q_s    = $signed({2'b00, quo_reg});
        grav_s = $signed({{(OSUM_W - GRAV_W){1'b0}}, cfg.gravity_ug});
        if (neg_reg)
        begin
            q_s = -q_s;
        end
        ofs_sum = q_s;
        if (cmd.axis == AXIS_W'(ACCEL_Z_AXIS))
        begin
            ofs_sum = q_s - grav_s;
        end
        if (ofs_sum > OFS_HI)
        begin
            ofs_sat = OFS_HI;
        end
        else if (ofs_sum < OFS_LO)
        begin
            ofs_sat = OFS_LO;
        end
        else
        begin
            ofs_sat = ofs_sum;
        end
    end

    always_comb
    begin
        diff = $signed(prod_reg[DIFF_W-1:0]) - DIFF_W'(ofs_reg[cmd.sub_axis]);
        if (cmd.sub_axis < AXIS_W'(GYRO_AXES))
        begin
            res_sat = (diff > GYR_HI) ? GYR_HI : ((diff < GYR_LO) ? GYR_LO : diff);
        end
        else
        begin
            res_sat = (diff > ACC_HI) ? ACC_HI : ((diff < ACC_LO) ? ACC_LO : diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                sum_reg[i] <= '0;
                ofs_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.accum)
            begin
                frames_reg <= frames_inc;
                for (int i = 0; i < AXIS_COUNT; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(raw_reg[i]);
                end
            end
            if (cmd.cal_store)
            begin
                ofs_reg[cmd.axis] <= $signed(ofs_sat[OFS_W-1:0]);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                raw_reg[i] <= raw_in[i];
            end
        end
        if (cmd.cal_mul)
        begin
            prod_reg <= cal_prod;
        end
        else if (cmd.run_mul)
        begin
            prod_reg <= PROD_W'(run_prod);
        end
        if (cmd.div_load)
        begin
            quo_reg   <= dividend;
            rem_reg   <= '0;
            div_d_reg <= divisor;
            neg_reg   <= prod_reg[PROD_W-1];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? rem_sub : trial;
        end
        if (cmd.run_sub)
        begin
            res_reg[cmd.sub_axis] <= $signed(res_sat[ACC_W-1:0]);
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                out_reg[i] <= res_reg[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res_out   = out_reg;

endmodule

// File: sim/tb_imu_bias_calibrate_and_correct_top.sv
// Self-checking testbench for the IMU bias calibration and correction block.
`timescale 1ns / 1ps

module tb_imu_bias_calibrate_and_correct_top;
    import imubc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd12;
    localparam int SETTLE_CYCLES  = 300;
    localparam int TAIL_CYCLES    = 32;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 7;
    localparam int PHASE_ITEMS    = 90;
    localparam longint OFS_HI = (longint'(1) << (OFS_W - 1)) - 1;
    localparam longint OFS_LO = -(longint'(1) << (OFS_W - 1));
    localparam longint ACC_HI = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) << (ACC_W - 1));
    localparam longint GYR_HI = (longint'(1) << (GYR_W - 1)) - 1;
    localparam longint GYR_LO = -(longint'(1) << (GYR_W - 1));

    typedef struct packed {
        logic [RAW_W-1:0] gx;
        logic [RAW_W-1:0] gy;
        logic [RAW_W-1:0] gz;
        logic [RAW_W-1:0] ax;
        logic [RAW_W-1:0] ay;
        logic [RAW_W-1:0] az;
    } frame_t;

    typedef struct packed {
        logic [ACC_W-1:0] ax;
        logic [ACC_W-1:0] ay;
        logic [ACC_W-1:0] az;
        logic [GYR_W-1:0] gx;
        logic [GYR_W-1:0] gy;
        logic [GYR_W-1:0] gz;
    } imu_out_t;

    typedef struct packed {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        frame_t                frame;
        bit                    typed;
        imu_out_t              want;
    } step_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [RAW_W-1:0] gyro_x;
    logic signed [RAW_W-1:0] gyro_y;
    logic signed [RAW_W-1:0] gyro_z;
    logic signed [RAW_W-1:0] accel_x;
    logic signed [RAW_W-1:0] accel_y;
    logic signed [RAW_W-1:0] accel_z;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [ACC_W-1:0] accel_x_ug;
    logic signed [ACC_W-1:0] accel_y_ug;
    logic signed [ACC_W-1:0] accel_z_ug;
    logic signed [GYR_W-1:0] gyro_x_mdps;
    logic signed [GYR_W-1:0] gyro_y_mdps;
    logic signed [GYR_W-1:0] gyro_z_mdps;

    // predictor copy of registers and state
    logic [CAL_W-1:0]   cal_count  = AVG_FRAMES_RST;
    logic [AGAIN_W-1:0] a_gain     = ACCEL_GAIN_RST;
    logic [GGAIN_W-1:0] g_gain     = GYRO_GAIN_RST;
    logic [GRAV_W-1:0]  grav_ug    = GRAVITY_RST;
    logic [CAL_W-1:0]   cal_frames = '0;
    bit                 calibrated = 1'b0;
    longint             axis_sum [AXIS_COUNT];
    longint             bias_ofs [AXIS_COUNT];

    imu_out_t pending_q [$];
    step_t    plan_q [$];

    int err_count    = 0;
    int frames_sent  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    bit tx_gaps      = 1'b1;
    bit rx_stalls    = 1'b1;

    imu_bias_calibrate_and_correct_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .gyro_x      (gyro_x),
        .gyro_y      (gyro_y),
        .gyro_z      (gyro_z),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accel_x_ug  (accel_x_ug),
        .accel_y_ug  (accel_y_ug),
        .accel_z_ug  (accel_z_ug),
        .gyro_x_mdps (gyro_x_mdps),
        .gyro_y_mdps (gyro_y_mdps),
        .gyro_z_mdps (gyro_z_mdps)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // nearest, halves away from zero
    function automatic longint round_div(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic bit correct_frame(input frame_t f, output imu_out_t r);
        longint raw [AXIS_COUNT];
        longint gain;
        longint ofs;
        int unsigned need;
        int i;
        raw[0] = $signed(f.gx);
        raw[1] = $signed(f.gy);
        raw[2] = $signed(f.gz);
        raw[3] = $signed(f.ax);
        raw[4] = $signed(f.ay);
        raw[5] = $signed(f.az);
        r = '0;
        if (!calibrated)
        begin
            need = (cal_count == 0) ? 1 : cal_count;
            for (i = 0; i < AXIS_COUNT; i++)
                axis_sum[i] += raw[i];
            cal_frames = cal_frames + 1'b1;
            if (cal_frames >= need)
            begin
                for (i = 0; i < AXIS_COUNT; i++)
                begin
                    gain = (i < GYRO_AXES) ? longint'(g_gain) : longint'(a_gain);
                    ofs = round_div(axis_sum[i] * gain, longint'(cal_frames));
                    if (i == ACCEL_Z_AXIS)
                        ofs -= longint'(grav_ug);
                    bias_ofs[i] = clip(ofs, OFS_LO, OFS_HI);
                end
                calibrated = 1'b1;
            end
            return 1'b0;
        end
        r.ax = ACC_W'(clip(raw[3] * longint'(a_gain) - bias_ofs[3], ACC_LO, ACC_HI));
        r.ay = ACC_W'(clip(raw[4] * longint'(a_gain) - bias_ofs[4], ACC_LO, ACC_HI));
        r.az = ACC_W'(clip(raw[5] * longint'(a_gain) - bias_ofs[5], ACC_LO, ACC_HI));
        r.gx = GYR_W'(clip(raw[0] * longint'(g_gain) - bias_ofs[0], GYR_LO, GYR_HI));
        r.gy = GYR_W'(clip(raw[1] * longint'(g_gain) - bias_ofs[1], GYR_LO, GYR_HI));
        r.gz = GYR_W'(clip(raw[2] * longint'(g_gain) - bias_ofs[2], GYR_LO, GYR_HI));
        return 1'b1;
    endfunction

    function automatic frame_t mkf(input int gx, input int gy, input int gz,
                                   input int ax, input int ay, input int az);
        frame_t f;
        f.gx = RAW_W'(gx);
        f.gy = RAW_W'(gy);
        f.gz = RAW_W'(gz);
        f.ax = RAW_W'(ax);
        f.ay = RAW_W'(ay);
        f.az = RAW_W'(az);
        return f;
    endfunction

    function automatic imu_out_t mko(input int ax, input int ay, input int az,
                                     input int gx, input int gy, input int gz);
        imu_out_t r;
        r.ax = ACC_W'(ax);
        r.ay = ACC_W'(ay);
        r.az = ACC_W'(az);
        r.gx = GYR_W'(gx);
        r.gy = GYR_W'(gy);
        r.gz = GYR_W'(gz);
        return r;
    endfunction

    function automatic logic [RAW_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return RAW_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s = '0;
        s.is_write = 1'b1;
        s.idx = idx;
        s.data = data;
        plan_q.push_back(s);
    endfunction

    function automatic void add_frame(input frame_t f);
        step_t s;
        s = '0;
        s.frame = f;
        plan_q.push_back(s);
    endfunction

    function automatic void add_check(input frame_t f, input imu_out_t want);
        step_t s;
        s = '0;
        s.frame = f;
        s.typed = 1'b1;
        s.want = want;
        plan_q.push_back(s);
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
        if (got !== want)
            note_error($sformatf("result %0d %s got %0d want %0d",
                                 results_seen, name, got, want));
    endtask

    // entered and left at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_AVG_FRAMES: cal_count = data[CAL_W-1:0];
            CFG_ACCEL_GAIN: a_gain    = data[AGAIN_W-1:0];
            CFG_GYRO_GAIN:  g_gain    = data[GGAIN_W-1:0];
            CFG_GRAVITY:    grav_ug   = data[GRAV_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_frame(input frame_t f, input bit typed, input imu_out_t want);
        imu_out_t calc;
        bit has_res;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid = 1'b1;
        gyro_x   = f.gx;
        gyro_y   = f.gy;
        gyro_z   = f.gz;
        accel_x  = f.ax;
        accel_y  = f.ay;
        accel_z  = f.az;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has_res = correct_frame(f, calc);
        if (typed)
            pending_q.push_back(want);
        else if (has_res)
            pending_q.push_back(calc);
        frames_sent++;
        @(negedge clk);
    endtask

    // calibration frames give no result, so also wait out the offset divider
    task automatic settle();
        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (rx_stalls && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge clk)
    begin : check_out
        imu_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_q.size() == 0)
                note_error($sformatf("result %0d arrived with nothing pending", results_seen));
            else
            begin
                want = pending_q.pop_front();
                cmp_field("accel_x_ug", accel_x_ug, $signed(want.ax));
                cmp_field("accel_y_ug", accel_y_ug, $signed(want.ay));
                cmp_field("accel_z_ug", accel_z_ug, $signed(want.az));
                cmp_field("gyro_x_mdps", gyro_x_mdps, $signed(want.gx));
                cmp_field("gyro_y_mdps", gyro_y_mdps, $signed(want.gy));
                cmp_field("gyro_z_mdps", gyro_z_mdps, $signed(want.gz));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        step_t row;
        logic [CFG_DATA_W-1:0] ag;
        logic [CFG_DATA_W-1:0] gg;
        logic [CFG_IDX_W-1:0] spare;
        bit after_frame;
        int k;
        int ph;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        gyro_x    = '0;
        gyro_y    = '0;
        gyro_z    = '0;
        accel_x   = '0;
        accel_y   = '0;
        accel_z   = '0;
        after_frame = 1'b0;
        for (k = 0; k < AXIS_COUNT; k++)
        begin
            axis_sum[k] = 0;
            bias_ofs[k] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // calibrate over four frames: count starts at max, dropped to zero mid-way
        add_write(CFG_AVG_FRAMES, 24'hFFFFFF);
        add_write(CFG_ACCEL_GAIN, 24'd1);
        add_write(CFG_GYRO_GAIN, 24'h00007F);
        add_write(CFG_GRAVITY, 24'hFFFFFF);
        add_write(CFG_IDX_SPARE, 24'd0);
        add_frame(mkf(32767, 32767, 32767, 32767, 32767, 32767));
        add_frame(mkf(-32768, -32768, -32768, -32768, -32768, -32768));
        add_frame(mkf(1, 1, 1, 1, 1, 1));
        add_write(CFG_AVG_FRAMES, 24'd0);
        add_frame(mkf(-2, 1, 0, 2, -1, -2));
        // offsets now gyro -64/32/0, accel 1/0/-16777216
        add_check(mkf(0, 0, 0, 0, 0, 0), mko(-1, 0, 16777216, 64, -32, 0));
        add_check(mkf(32767, 32767, 32767, 32767, 32767, 32767),
                  mko(32766, 32767, 16809983, 4161473, 4161377, 4161409));
        add_check(mkf(-32768, -32768, -32768, -32768, -32768, -32768),
                  mko(-32769, -32768, 16744448, -4161472, -4161568, -4161536));
        add_write(CFG_ACCEL_GAIN, 24'd1000);
        add_write(CFG_GYRO_GAIN, 24'd100);
        add_frame(mkf(32767, -32768, 12345, -32768, 32767, -1));
        add_frame(mkf(1, -1, 0, -1, 1, 0));
        add_frame(mkf(-32768, 32767, -1, 32767, -32768, 0));
        add_write(CFG_ACCEL_GAIN, 24'd0);
        add_write(CFG_GYRO_GAIN, 24'd0);
        add_check(mkf(32767, 32767, 32767, 32767, 32767, 32767),
                  mko(-1, 0, 16777216, 64, -32, 0));
        add_write(CFG_GRAVITY, 24'd16000000);
        add_write(CFG_AVG_FRAMES, 24'd1);

        for (k = 0; k < plan_q.size(); k++)
        begin
            row = plan_q[k];
            if (row.is_write)
            begin
                if (after_frame)
                    settle();
                after_frame = 1'b0;
                write_reg(row.idx, row.data);
            end
            else
            begin
                send_frame(row.frame, row.typed, row.want);
                after_frame = 1'b1;
            end
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    ag = 24'd1000;
                    gg = 24'd100;
                end
                1:
                begin
                    ag = 24'd1;
                    gg = 24'd1;
                end
                2:
                begin
                    ag = CFG_DATA_W'($urandom);
                    gg = CFG_DATA_W'($urandom);
                end
                3:
                begin
                    ag = 24'd1023;
                    gg = 24'd127;
                end
                default:
                begin
                    ag = CFG_DATA_W'($urandom_range(1, 1000));
                    gg = CFG_DATA_W'($urandom_range(1, 100));
                end
            endcase
            spare = CFG_IDX_W'($urandom_range(4, 15));
            write_reg(CFG_ACCEL_GAIN, ag);
            write_reg(CFG_GYRO_GAIN, gg);
            write_reg(CFG_AVG_FRAMES, CFG_DATA_W'($urandom));
            write_reg(CFG_GRAVITY, CFG_DATA_W'($urandom));
            write_reg(spare, CFG_DATA_W'($urandom));
            @(posedge clk);
            tx_gaps   = (ph != 4) && (ph != RAND_PHASES - 1);
            rx_stalls = (ph != RAND_PHASES - 1);
            if (ph == 2)
                hold_left = LONG_HOLD;
            @(negedge clk);
            repeat (PHASE_ITEMS)
                send_frame(mkf(pick_word(), pick_word(), pick_word(),
                               pick_word(), pick_word(), pick_word()), 1'b0, '0);
        end

        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Run covered %0d frames (calibration with count drop, gain extremes)",
                 frames_sent);
        $display("and %0d corrected results under %0d register writes with back-pressure",
                 results_seen, cfg_writes);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
